// ===== rtl/heightfield_four_pass_smoother_core_assert.svh =====
// Assertion macros shared by the smoother RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef HEIGHTFIELD_FOUR_PASS_SMOOTHER_CORE_ASSERT_SVH
`define HEIGHTFIELD_FOUR_PASS_SMOOTHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define HFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define HFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HFS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define HFS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/hfs_pkg.sv =====
package hfs_pkg;

   // Grid geometry and stored height width.
   localparam int MAX_COLS    = 64;
   localparam int MAX_ROWS    = 64;
   localparam int HEIGHT_BITS = 24;

   // Derived sizes.
   localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int IDX_W    = $clog2(MAX_DIM);
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);

   // Fixed field widths of the ports.
   localparam int HEIGHT_IO_W = 24;
   localparam int WEIGHT_W    = 17;
   localparam int SIZE_W      = 7;
   localparam int CSR_IDX_W   = 2;

   // Weight of one in Q1.16.
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // Request codes.
   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_SMOOTH = 2'd2;

   // Response kinds.
   localparam logic RSP_READ = 1'b0;
   localparam logic RSP_DONE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd1;

   // Last of the four smoothing passes.
   localparam logic [1:0] PASS_LAST = 2'd3;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic [5:0]                    row_index;
      logic [5:0]                    col_index;
      logic signed [HEIGHT_IO_W-1:0] height_in;
      logic [WEIGHT_W-1:0]           smooth_factor;
   } hfs_req_type;

   typedef struct packed {
      logic                          resp_kind;
      logic signed [HEIGHT_IO_W-1:0] height_out;
   } hfs_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_RD,
      ST_SEED_LD,
      ST_RD,
      ST_LD,
      ST_MUL,
      ST_RND,
      ST_WR
   } hfs_state_type;

   // Clamps a used size into 2..maxv and returns the last index.
   function automatic int sat_last(input int v, input int maxv);
      int s;
      s = v;
      if (s < 2) s = 2;
      if (s > maxv) s = maxv;
      return s - 1;
   endfunction

endpackage

// ===== rtl/hfs_ram.sv =====
module hfs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, read-first, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      rd_data_ff <= store_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hfs_blend.sv =====
module hfs_blend (
   input  logic                                        clock,
   input  logic signed [hfs_pkg::HEIGHT_BITS-1:0]      height_cur,
   input  logic signed [hfs_pkg::HEIGHT_BITS-1:0]      height_nbr,
   input  logic [hfs_pkg::WEIGHT_W-1:0]                weight,
   output logic signed [hfs_pkg::HEIGHT_BITS-1:0]      height_blend
);

   import hfs_pkg::*;

   localparam int D_W = HEIGHT_BITS + 1;
   localparam int P_W = D_W + WEIGHT_W + 1;
   localparam logic signed [P_W-1:0] HALF = P_W'(32768);

   logic signed [HEIGHT_BITS-1:0] h1_ff;
   logic signed [D_W-1:0]         d1_ff;
   logic signed [HEIGHT_BITS-1:0] h2_ff;
   logic signed [P_W-1:0]         p2_ff;
   logic signed [HEIGHT_BITS-1:0] res_ff;
   logic signed [D_W-1:0]         diff;
   logic signed [WEIGHT_W:0]      weight_s;
   logic signed [P_W-1:0]         p_round;
   logic signed [P_W-1:0]         p_shift;

   // h*(1-k) + n*k is rewritten as h + (n-h)*k, which needs one multiply.
   assign diff     = D_W'(height_nbr) - D_W'(height_cur);
   assign weight_s = signed'({1'b0, weight});
   assign p_round  = p2_ff + HALF;
   assign p_shift  = p_round >>> 16;

   // Three stages: difference, product, round and add back.
   always_ff @(posedge clock) begin
      h1_ff  <= height_cur;
      d1_ff  <= diff;
      h2_ff  <= h1_ff;
      p2_ff  <= d1_ff * weight_s;
      res_ff <= h2_ff + HEIGHT_BITS'(p_shift);
   end

   assign height_blend = res_ff;

endmodule

// ===== rtl/heightfield_four_pass_smoother_core.sv =====
// Height grid smoother. A write or read request is taken while busy is low
// and leaves busy low, so reads and writes run at one per cycle until a
// smooth request raises busy; a read answer is on the rsp_ ports with
// rsp_strobe in the cycle after the request is taken, and the receiver
// cannot stall it, so it must be sampled then. A smooth request raises
// busy until it is done and works on the used rows and columns, clamped
// to 2..64 each; the finished strobe comes in the cycle after the last
// write, as busy falls. Each sample goes through a registered memory
// read, a three-stage blend unit and a write back through the single
// memory port, after each row or column is seeded from its first sample.
// Configuration writes are taken whenever busy is low.
`include "heightfield_four_pass_smoother_core_assert.svh"

module heightfield_four_pass_smoother_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  hfs_pkg::hfs_req_type                  req_item,
   output logic                                  rsp_strobe,
   output hfs_pkg::hfs_rsp_type                  rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hfs_pkg::SIZE_W-1:0]            csr_wdata
);

   import hfs_pkg::*;

   // Control registers.
   hfs_state_type      state_ff, state_in;
   logic [1:0]         pass_ff, pass_in;
   logic [IDX_W-1:0]   line_ff, line_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [SIZE_W-1:0]  cols_ff, cols_in;
   logic [SIZE_W-1:0]  rows_ff, rows_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_kind_ff, rsp_kind_in;

   // Payload registers.
   logic signed [HEIGHT_BITS-1:0] nbr_ff, nbr_in;
   logic [WEIGHT_W-1:0]           k_ff, k_in;
   logic [IDX_W-1:0]              nc_last_ff, nc_last_in;
   logic [IDX_W-1:0]              nr_last_ff, nr_last_in;
   logic                          rd_ok_ff, rd_ok_in;

   // Memory port.
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_addr;
   logic [HEIGHT_BITS-1:0]        ram_wdata;
   logic [HEIGHT_BITS-1:0]        ram_rdata;
   logic signed [HEIGHT_BITS-1:0] ram_rdata_s;
   logic signed [HEIGHT_BITS-1:0] blend_res;

   // Sequencer decode.
   logic              horiz, desc;
   logic [IDX_W-1:0]  inner_last, line_last, inner_end, line_start, pos_step;
   logic [1:0]        pass_next;
   logic [IDX_W-1:0]  next_pass_start;
   logic [IDX_W-1:0]  seq_row, seq_col;
   logic [ADDR_W-1:0] seq_addr, req_addr;
   logic              req_addr_ok;

   assign ram_rdata_s = signed'(ram_rdata);

   // Height memory.
   hfs_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Shared blend unit.
   hfs_blend u_blend (
      .clock        (clock),
      .height_cur   (ram_rdata_s),
      .height_nbr   (nbr_ff),
      .weight       (k_ff),
      .height_blend (blend_res)
   );

   // Pass geometry: even passes walk rows, the upper two walk backward.
   always_comb begin
      horiz      = ~pass_ff[0];
      desc       = pass_ff[1];
      inner_last = horiz ? nc_last_ff : nr_last_ff;
      line_last  = horiz ? nr_last_ff : nc_last_ff;
      inner_end  = desc ? '0 : inner_last;
      line_start = desc ? inner_last : '0;
      pos_step   = desc ? (pos_ff - 1'b1) : (pos_ff + 1'b1);
      pass_next  = pass_ff + 2'd1;
      if (pass_next[1]) begin
         next_pass_start = pass_next[0] ? nr_last_ff : nc_last_ff;
      end else begin
         next_pass_start = '0;
      end
      seq_row  = horiz ? line_ff : pos_ff;
      seq_col  = horiz ? pos_ff : line_ff;
      seq_addr = ADDR_W'(seq_row) * ADDR_W'(MAX_COLS) + ADDR_W'(seq_col);
   end

   // Request address.
   always_comb begin
      req_addr_ok = (32'(req_item.row_index) < MAX_ROWS) &&
                    (32'(req_item.col_index) < MAX_COLS);
      req_addr    = ADDR_W'(IDX_W'(req_item.row_index)) * ADDR_W'(MAX_COLS) +
                    ADDR_W'(IDX_W'(req_item.col_index));
   end

   // Next state and outputs.
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      line_in       = line_ff;
      pos_in        = pos_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      nbr_in        = nbr_ff;
      k_in          = k_ff;
      nc_last_in    = nc_last_ff;
      nr_last_in    = nr_last_ff;
      rd_ok_in      = rd_ok_ff;
      ram_we        = 1'b0;
      ram_addr      = seq_addr;
      ram_wdata     = blend_res;

      // Configuration beat.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLS: cols_in = csr_wdata;
            CSR_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            ram_addr  = req_addr;
            ram_wdata = HEIGHT_BITS'(req_item.height_in);
            if (start) begin
               case (req_item.req_type)
                  REQ_WRITE: begin
                     ram_we = req_addr_ok;
                  end
                  REQ_READ: begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = RSP_READ;
                     rd_ok_in      = req_addr_ok;
                  end
                  REQ_SMOOTH: begin
                     k_in       = (req_item.smooth_factor > WEIGHT_ONE) ?
                                  WEIGHT_ONE : req_item.smooth_factor;
                     nc_last_in = IDX_W'(sat_last(int'(cols_ff), MAX_COLS));
                     nr_last_in = IDX_W'(sat_last(int'(rows_ff), MAX_ROWS));
                     pass_in    = '0;
                     line_in    = '0;
                     pos_in     = '0;
                     state_in   = ST_SEED_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEED_RD: begin
            state_in = ST_SEED_LD;
         end
         ST_SEED_LD: begin
            // The first sample of a line is the neighbor of the second.
            nbr_in   = ram_rdata_s;
            pos_in   = pos_step;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_LD;
         end
         ST_LD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            ram_we = 1'b1;
            nbr_in = blend_res;
            if (pos_ff == inner_end) begin
               if (line_ff == line_last) begin
                  if (pass_ff == PASS_LAST) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = RSP_DONE;
                     state_in      = ST_IDLE;
                  end else begin
                     pass_in  = pass_next;
                     line_in  = '0;
                     pos_in   = next_pass_start;
                     state_in = ST_SEED_RD;
                  end
               end else begin
                  line_in  = line_ff + 1'b1;
                  pos_in   = line_start;
                  state_in = ST_SEED_RD;
               end
            end else begin
               pos_in   = pos_step;
               state_in = ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= '0;
         line_ff       <= '0;
         pos_ff        <= '0;
         cols_ff       <= 7'd64;
         rows_ff       <= 7'd64;
         rsp_strobe_ff <= 1'b0;
         rsp_kind_ff   <= RSP_READ;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         line_ff       <= line_in;
         pos_ff        <= pos_in;
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      nbr_ff     <= nbr_in;
      k_ff       <= k_in;
      nc_last_ff <= nc_last_in;
      nr_last_ff <= nr_last_in;
      rd_ok_ff   <= rd_ok_in;
   end

   // Port outputs.
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      csr_ready           = (state_ff == ST_IDLE);
      rsp_strobe          = rsp_strobe_ff;
      rsp_item.resp_kind  = rsp_kind_ff;
      if ((rsp_kind_ff == RSP_READ) && rd_ok_ff) begin
         rsp_item.height_out = HEIGHT_IO_W'(ram_rdata_s);
      end else begin
         rsp_item.height_out = '0;
      end
   end

   // Checks.
   `HFS_ASSERT_IMPL(a_done_after_write, clock, reset, rsp_strobe_ff && (rsp_kind_ff == RSP_DONE), $past(state_ff == ST_WR))
   `HFS_ASSERT_NEXT(a_read_answers, clock, reset, start && !busy && (req_item.req_type == REQ_READ), rsp_strobe_ff && (rsp_kind_ff == RSP_READ))
   `HFS_ASSERT_IMPL(a_pos_in_range, clock, reset, state_ff != ST_IDLE, pos_ff <= inner_last)
   `HFS_ASSERT_IMPL(a_line_in_range, clock, reset, state_ff != ST_IDLE, line_ff <= line_last)

endmodule
